// File: src/stepper_sweep_controller_defines.svh
// assertion helpers for the stepper sweep controller
`ifndef STEPPER_SWEEP_CONTROLLER_DEFINES_SVH
`define STEPPER_SWEEP_CONTROLLER_DEFINES_SVH

// condition holds in the same cycle
`define SSC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/ssc_pkg.sv
package ssc_pkg;

   localparam int unsigned TICK_W = 24;
   localparam int unsigned SPAN_W = 23;
   localparam int unsigned POS_W  = 24;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // register reset values
   localparam logic [SPAN_W-1:0] SPAN_RESET    = 23'd3008;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd3000;
   localparam logic [TICK_W-1:0] DWELL_RESET   = 24'd2000;

   // register indexes of the control port
   typedef enum logic [2:0] {
      CSR_HALF_PERIOD = 3'd0,
      CSR_REVERSE     = 3'd1,
      CSR_SWEEP_SPAN  = 3'd2,
      CSR_HOME_TMO    = 3'd3,
      CSR_DWELL       = 3'd4
   } csr_index_type;

   // command codes of an input item
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_RESUME  = 2'd1,
      CMD_HOLD    = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [TICK_W-1:0] half_period_ticks;
      logic              reverse;
      logic [SPAN_W-1:0] sweep_span;
      logic [TICK_W-1:0] homing_timeout;
      logic [TICK_W-1:0] dwell_time;
   } cfg_type;

   // step generator state
   typedef struct packed {
      logic [TICK_W-1:0]       divider;
      logic                    phase;
      logic                    dir_pin;
      logic signed [POS_W-1:0] count;
   } gen_type;

   typedef struct packed {
      logic                    step_out;
      logic                    dir_out;
      logic                    motor_enable;
      logic [1:0]              mode;
      logic signed [POS_W-1:0] position;
      logic                    stop_event;
   } result_type;

   // clamp a one-bit-wider sum back into the position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
      logic signed [POS_W-1:0] r;
      if (v[POS_W] != v[POS_W-1]) begin
         r = v[POS_W] ? POS_MIN : POS_MAX;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/ssc_req_if.sv
interface ssc_req_if;
   logic       valid;
   logic       ready;
   logic       home_switch;
   logic [1:0] command;

   modport source (output valid, output home_switch, output command, input ready);
   modport sink (input valid, input home_switch, input command, output ready);
endinterface

// File: src/ssc_rsp_if.sv
interface ssc_rsp_if;
   logic               valid;
   logic               ready;
   logic               step_out;
   logic               dir_out;
   logic               motor_enable;
   logic [1:0]         mode;
   logic signed [23:0] position;
   logic               stop_event;

   modport source (output valid, output step_out, output dir_out, output motor_enable,
                   output mode, output position, output stop_event, input ready);
   modport sink (input valid, input step_out, input dir_out, input motor_enable,
                 input mode, input position, input stop_event, output ready);
endinterface

// File: src/ssc_csr_if.sv
interface ssc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/stepper_sweep_controller.sv
// an accepted item passes the input register, then the result register; the whole tick
// update sits between the two; throughput: one item per cycle unless the result stalls
// a stalled result holds while the input register still takes one more item
// reset: synchronous, active high; mode goes to init, counters and flags clear,
// control registers return to their reset values, both channels empty
module stepper_sweep_controller (
   input logic       clock,
   input logic       reset,
   ssc_req_if.sink   req_ch,
   ssc_rsp_if.source rsp_ch,
   ssc_csr_if.sink   csr_ch
);
   import ssc_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_switch_ff;
   logic [1:0] in_command_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       advance;

   // item moves from input register to result register
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= '0;
         cfg_ff.reverse           <= 1'b0;
         cfg_ff.sweep_span        <= SPAN_RESET;
         cfg_ff.homing_timeout    <= TIMEOUT_RESET;
         cfg_ff.dwell_time        <= DWELL_RESET;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_ch.data;
            CSR_REVERSE:     cfg_ff.reverse           <= csr_ch.data[0];
            CSR_SWEEP_SPAN:  cfg_ff.sweep_span        <= csr_ch.data[SPAN_W-1:0];
            CSR_HOME_TMO:    cfg_ff.homing_timeout    <= csr_ch.data;
            CSR_DWELL:       cfg_ff.dwell_time        <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_switch_ff  <= req_ch.home_switch;
         in_command_ff <= req_ch.command;
      end
   end

   ssc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .tick        (advance),
      .home_switch (in_switch_ff),
      .command     (in_command_ff),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.step_out     = out_ff.step_out;
   assign rsp_ch.dir_out      = out_ff.dir_out;
   assign rsp_ch.motor_enable = out_ff.motor_enable;
   assign rsp_ch.mode         = out_ff.mode;
   assign rsp_ch.position     = out_ff.position;
   assign rsp_ch.stop_event   = out_ff.stop_event;

endmodule

// File: src/ssc_step_gen.sv
module ssc_step_gen (
   input  logic                         enable,
   input  logic [ssc_pkg::TICK_W-1:0]   period,
   input  logic                         dir_latch,
   input  ssc_pkg::gen_type             gen_cur,
   output ssc_pkg::gen_type             gen_next
);
   import ssc_pkg::*;

   logic [TICK_W-1:0]      div_inc;
   logic signed [POS_W:0]  step_sum;

   // saturating divider count
   assign div_inc = (gen_cur.divider == {TICK_W{1'b1}}) ? gen_cur.divider
                                                        : gen_cur.divider + 1'b1;

   // one step up or down, one bit wider for the clamp
   assign step_sum = dir_latch ? ({gen_cur.count[POS_W-1], gen_cur.count} - 1'sb1)
                               : ({gen_cur.count[POS_W-1], gen_cur.count} + 1'sb1);

   // toggle the step pin every half period, count on the rising edge
   always_comb begin
      gen_next = gen_cur;
      if (enable) begin
         gen_next.divider = div_inc;
         if (div_inc >= period) begin
            gen_next.divider = '0;
            gen_next.phase   = ~gen_cur.phase;
            if (!gen_cur.phase) begin
               gen_next.count = sat_pos(step_sum);
            end else begin
               gen_next.dir_pin = dir_latch;
            end
         end
      end
   end

endmodule

// File: src/ssc_core.sv
`include "stepper_sweep_controller_defines.svh"

module ssc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick,
   input  logic                 home_switch,
   input  logic [1:0]           command,
   input  ssc_pkg::cfg_type     cfg,
   output ssc_pkg::result_type  result
);
   import ssc_pkg::*;

   typedef enum logic [1:0] {
      MODE_INIT   = 2'd0,
      MODE_HOMING = 2'd1,
      MODE_SWEEP  = 2'd2,
      MODE_STOP   = 2'd3
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [TICK_W-1:0] time_ff, time_in;
   logic              pending_ff, pending_in;
   logic              hold_ff, hold_in;
   logic              enable_ff, enable_in;
   logic [TICK_W-1:0] period_ff, period_in;
   logic              dir_latch_ff, dir_latch_in;
   gen_type           gen_ff, gen_in, gen_mid;
   logic              stop_now;
   logic              start_req;

   // command, then one mode transition
   always_comb begin
      mode_in      = mode_ff;
      pending_in   = pending_ff;
      hold_in      = hold_ff;
      enable_in    = enable_ff;
      period_in    = period_ff;
      dir_latch_in = dir_latch_ff;
      gen_mid      = gen_ff;
      stop_now     = 1'b0;
      start_req    = 1'b0;
      time_in      = (time_ff == {TICK_W{1'b1}}) ? time_ff : time_ff + 1'b1;

      case (cmd_type'(command))
         CMD_RESUME: begin
            pending_in = 1'b1;
         end
         CMD_HOLD: begin
            hold_in = 1'b1;
            if (mode_ff != MODE_STOP) begin
               mode_in   = MODE_STOP;
               time_in   = '0;
               enable_in = 1'b0;
               stop_now  = 1'b1;
            end
         end
         CMD_RELEASE: begin
            hold_in = 1'b0;
         end
         default: begin
         end
      endcase

      case (mode_in)
         MODE_INIT: begin
            mode_in   = MODE_HOMING;
            time_in   = '0;
            start_req = 1'b1;
         end
         MODE_HOMING: begin
            if (home_switch || (time_in > cfg.homing_timeout)) begin
               gen_mid.count = '0;
               mode_in       = MODE_SWEEP;
               time_in       = '0;
               start_req     = 1'b1;
            end
         end
         MODE_SWEEP: begin
            if (gen_mid.count > $signed({1'b0, cfg.sweep_span})) begin
               mode_in   = MODE_STOP;
               time_in   = '0;
               enable_in = 1'b0;
               stop_now  = 1'b1;
            end
         end
         MODE_STOP: begin
            if ((pending_in || (time_in > cfg.dwell_time)) && !hold_in) begin
               pending_in    = 1'b0;
               gen_mid.count = sat_pos({gen_mid.count[POS_W-1], gen_mid.count}
                                       - $signed({2'b00, cfg.sweep_span}));
               mode_in       = MODE_SWEEP;
               time_in       = '0;
               start_req     = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // motor start latches speed and direction; a zero speed keeps the motor off
      if (start_req) begin
         if (cfg.half_period_ticks == '0) begin
            enable_in = 1'b0;
         end else begin
            enable_in    = 1'b1;
            period_in    = cfg.half_period_ticks;
            dir_latch_in = cfg.reverse;
         end
      end
   end

   ssc_step_gen u_step_gen (
      .enable    (enable_in),
      .period    (period_in),
      .dir_latch (dir_latch_in),
      .gen_cur   (gen_mid),
      .gen_next  (gen_in)
   );

   // state after this tick
   assign result.step_out     = gen_in.phase;
   assign result.dir_out      = gen_in.dir_pin;
   assign result.motor_enable = enable_in;
   assign result.mode         = mode_in;
   assign result.position     = gen_in.count;
   assign result.stop_event   = stop_now;

   // mode and motor state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INIT;
         time_ff      <= '0;
         pending_ff   <= 1'b0;
         hold_ff      <= 1'b0;
         enable_ff    <= 1'b0;
         period_ff    <= '0;
         dir_latch_ff <= 1'b0;
         gen_ff       <= '0;
      end else if (tick) begin
         mode_ff      <= mode_in;
         time_ff      <= time_in;
         pending_ff   <= pending_in;
         hold_ff      <= hold_in;
         enable_ff    <= enable_in;
         period_ff    <= period_in;
         dir_latch_ff <= dir_latch_in;
         gen_ff       <= gen_in;
      end
   end

   `SSC_ASSERT_IMP(stop_keeps_motor_off, mode_ff == MODE_STOP, !enable_ff, "motor on in stop")
   `SSC_ASSERT_IMP(event_only_on_entry, stop_now,
                   (mode_in == MODE_STOP) && (mode_ff != MODE_STOP), "stray stop event")
   `SSC_ASSERT_IMP(hold_blocks_resume, tick && (mode_ff == MODE_STOP) && hold_in,
                   mode_in == MODE_STOP, "left stop while hold active")
   `SSC_ASSERT_NEXT(idle_keeps_state, !tick,
                    $stable(mode_ff) && $stable(gen_ff), "state moved without an item")

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import ssc_pkg::*;

   typedef enum logic [1:0] {
      MODE_INIT   = 2'd0,
      MODE_HOMING = 2'd1,
      MODE_SWEEP  = 2'd2,
      MODE_STOP   = 2'd3
   } ctrl_mode_type;

   // index past the end of the register list, must be ignored
   localparam logic [2:0] CSR_SPARE = 3'd6;

   typedef struct packed {
      logic       home_switch;
      cmd_type    command;
      logic       typed;
      result_type want;
   } tick_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssc_req_if req_if ();
   ssc_rsp_if rsp_if ();
   ssc_csr_if csr_if ();

   stepper_sweep_controller dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #5 clock = ~clock;

   int send_idle_pct = 27;
   int take_idle_pct = 81;
   int mismatches = 0;

   // hand-typed outputs for the directed rows that carry one
   logic       typed_on = 1'b0;
   result_type typed_val = '0;

   result_type tick_outputs_due [$];

   // controller state as predicted by the testbench
   cfg_type           regs = '{24'd0, 1'b0, SPAN_RESET, TIMEOUT_RESET, DWELL_RESET};
   ctrl_mode_type     st_mode = MODE_INIT;
   logic [23:0]       st_time = '0;
   logic [23:0]       st_divider = '0;
   logic [23:0]       st_period = '0;
   logic signed [23:0] st_pos = '0;
   logic st_resume = 1'b0;
   logic st_hold = 1'b0;
   logic st_phase = 1'b0;
   logic st_dir_pin = 1'b0;
   logic st_enable = 1'b0;
   logic st_dir_latch = 1'b0;
   logic st_stop_flag = 1'b0;

   function automatic logic signed [23:0] clip_position(input int v);
      if (v > int'(POS_MAX)) return POS_MAX;
      if (v < int'(POS_MIN)) return POS_MIN;
      return v[23:0];
   endfunction

   // mode change; homing and sweep start the motor with the current speed
   task automatic enter_state(input ctrl_mode_type next);
      if (next != st_mode) begin
         st_time = '0;
         if (next == MODE_HOMING || next == MODE_SWEEP) begin
            if (regs.half_period_ticks == '0) begin
               st_enable = 1'b0;
            end else begin
               st_enable = 1'b1;
               st_period = regs.half_period_ticks;
               st_dir_latch = regs.reverse;
            end
         end else if (next == MODE_STOP) begin
            st_enable = 1'b0;
            st_stop_flag = 1'b1;
         end
         st_mode = next;
      end
   endtask

   // one tick of the sweep controller
   task automatic advance_controller(input logic sw, input cmd_type cmd,
                                     output result_type r);
      st_stop_flag = 1'b0;
      if (st_time != '1) st_time++;

      case (cmd)
         CMD_RESUME: st_resume = 1'b1;
         CMD_HOLD: begin
            st_hold = 1'b1;
            enter_state(MODE_STOP);
         end
         CMD_RELEASE: st_hold = 1'b0;
         default: ;
      endcase

      case (st_mode)
         MODE_INIT: enter_state(MODE_HOMING);
         MODE_HOMING: begin
            if (sw || st_time > regs.homing_timeout) begin
               st_pos = '0;
               enter_state(MODE_SWEEP);
            end
         end
         MODE_SWEEP: begin
            if (int'(st_pos) > int'({1'b0, regs.sweep_span})) enter_state(MODE_STOP);
         end
         default: begin
            if ((st_resume || st_time > regs.dwell_time) && !st_hold) begin
               st_resume = 1'b0;
               st_pos = clip_position(int'(st_pos) - int'({1'b0, regs.sweep_span}));
               enter_state(MODE_SWEEP);
            end
         end
      endcase

      // step generator, halted while the motor is off
      if (st_enable) begin
         if (st_divider != '1) st_divider++;
         if (st_divider >= st_period) begin
            st_divider = '0;
            st_phase = ~st_phase;
            if (st_phase) begin
               st_pos = clip_position(int'(st_pos) + (st_dir_latch ? -1 : 1));
            end else begin
               st_dir_pin = st_dir_latch;
            end
         end
      end

      r = '{st_phase, st_dir_pin, st_enable, st_mode, st_pos, st_stop_flag};
   endtask

   task automatic check_field(input string field, input logic signed [24:0] want,
                              input logic signed [24:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // track register writes, predict each tick, check each output item
   always @(posedge clock) begin : track
      result_type predicted;
      result_type want;
      result_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.step_out, rsp_if.dir_out, rsp_if.motor_enable, rsp_if.mode,
                    rsp_if.position, rsp_if.stop_event};
            if (tick_outputs_due.size() == 0) begin
               mismatches++;
               $display("%0t ns: output item with no tick outstanding", $time);
            end else begin
               want = tick_outputs_due.pop_front();
               check_field("step_out", want.step_out, got.step_out);
               check_field("dir_out", want.dir_out, got.dir_out);
               check_field("motor_enable", want.motor_enable, got.motor_enable);
               check_field("mode", want.mode, got.mode);
               check_field("position", want.position, got.position);
               check_field("stop_event", want.stop_event, got.stop_event);
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_HALF_PERIOD: regs.half_period_ticks = csr_if.data;
               CSR_REVERSE:     regs.reverse = csr_if.data[0];
               CSR_SWEEP_SPAN:  regs.sweep_span = csr_if.data[22:0];
               CSR_HOME_TMO:    regs.homing_timeout = csr_if.data;
               CSR_DWELL:       regs.dwell_time = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            advance_controller(req_if.home_switch, cmd_type'(req_if.command), predicted);
            tick_outputs_due.push_back(typed_on ? typed_val : predicted);
         end
      end
   end

   // output side back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= take_idle_pct);
   end

   // leaves valid high so back-to-back items need no toggle
   task automatic push_tick(input logic sw, input cmd_type cmd, input logic has_typed,
                            input result_type typed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.home_switch <= sw;
      req_if.command <= cmd;
      typed_on <= has_typed;
      typed_val <= typed;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // unused upper bits of the narrow registers carry noise
   task automatic write_config(input cfg_type c, input logic with_spare);
      logic [23:0] noise;
      noise = 24'($urandom());
      if (with_spare) write_reg(CSR_SPARE, noise);
      write_reg(CSR_HALF_PERIOD, c.half_period_ticks);
      write_reg(CSR_REVERSE, {noise[23:1], c.reverse});
      write_reg(CSR_SWEEP_SPAN, {noise[0], c.sweep_span});
      write_reg(CSR_HOME_TMO, c.homing_timeout);
      write_reg(CSR_DWELL, c.dwell_time);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_outputs_drained();
      while (tick_outputs_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      tick_row_type script [24];
      cfg_type plan [7];
      cfg_type c;
      int      opening;
      int      roll;
      cmd_type cmd;

      req_if.valid = 1'b0;
      req_if.home_switch = 1'b0;
      req_if.command = CMD_NONE;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_HALF_PERIOD;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;

      // switch exit from homing, pending resume, holds, release
      script = '{
         '{1'b0, CMD_NONE,    1'b1, '{1'b1, 1'b0, 1'b1, MODE_HOMING, 24'sd1, 1'b0}},
         '{1'b1, CMD_NONE,    1'b1, '{1'b0, 1'b0, 1'b1, MODE_SWEEP, 24'sd0, 1'b0}},
         '{1'b0, CMD_RESUME,  1'b0, '0},
         '{1'b1, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b1, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_HOLD,    1'b0, '0},
         '{1'b0, CMD_HOLD,    1'b0, '0},
         '{1'b1, CMD_RESUME,  1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_RELEASE, 1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b1, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_RELEASE, 1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b0, CMD_RESUME,  1'b0, '0},
         '{1'b0, CMD_NONE,    1'b0, '0},
         '{1'b1, CMD_HOLD,    1'b0, '0},
         '{1'b0, CMD_RELEASE, 1'b0, '0}
      };

      // init and homing occur once per run, so the seed picks how homing ends
      opening = $urandom_range(0, 3);
      case (opening)
         1: begin
            // hold straight out of init, the switch then finds the block held in stop
            script[0].command = CMD_HOLD;
            script[0].want = '{1'b0, 1'b0, 1'b0, MODE_STOP, 24'sd0, 1'b1};
            script[1].typed = 1'b0;
         end
         2: begin
            // hold during homing
            script[1] = '{1'b0, CMD_HOLD, 1'b1,
                          '{1'b1, 1'b0, 1'b0, MODE_STOP, 24'sd1, 1'b1}};
         end
         3: begin
            // no switch, homing ends on the timeout
            for (int i = 1; i <= 8; i++) begin
               script[i].home_switch = 1'b0;
               script[i].typed = 1'b0;
            end
         end
         default: ;
      endcase

      // extremes, speed zero, huge span, reverse and random small settings
      plan = '{
         '{24'd1,        1'b0, 23'd5,        24'd4,        24'd3},
         '{24'd2,        1'b1, 23'd4,        24'd0,        24'd0},
         '{24'd0,        1'b0, 23'd3,        24'd6,        24'd2},
         '{24'hFFFFFF,   1'b0, 23'd2,        24'd5,        24'd1},
         '{24'd1,        1'b0, 23'd0,        24'hFFFFFF,   24'hFFFFFF},
         '{24'd3,        1'b0, 23'h7FFFFF,   24'd2,        24'd4},
         '{24'd1,        1'b1, 23'h7FFFFF,   24'd2,        24'd0}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed ticks
      write_config('{24'd1, 1'b0, 23'd3, 24'd4, 24'd2}, 1'b1);
      foreach (script[i]) begin
         push_tick(script[i].home_switch, script[i].command, script[i].typed,
                   script[i].want);
      end
      req_if.valid <= 1'b0;

      // random ticks, one register setting per phase
      for (int p = 0; p < 10; p++) begin
         case (p * 3 / 10)
            0: begin
               send_idle_pct = 27;
               take_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               take_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         if (p < 7) begin
            c = plan[p];
         end else begin
            c.half_period_ticks = 24'($urandom_range(1, 4));
            c.reverse = 1'($urandom_range(0, 1));
            c.sweep_span = 23'($urandom_range(0, 12));
            c.homing_timeout = 24'($urandom_range(0, 8));
            c.dwell_time = 24'($urandom_range(0, 10));
         end
         wait_outputs_drained();
         write_config(c, 1'b0);
         repeat (110) begin
            roll = $urandom_range(0, 99);
            cmd = (roll < 78) ? CMD_NONE :
                  (roll < 88) ? CMD_RESUME :
                  (roll < 94) ? CMD_HOLD : CMD_RELEASE;
            push_tick(1'($urandom_range(0, 1)), cmd, 1'b0, '0);
         end
         req_if.valid <= 1'b0;
      end

      wait_outputs_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
